// File: rtl/llm_pkg.sv
// Shared widths, codes, reset values and channel class tables for the liveness monitor.
package llm_pkg;

    localparam int unsigned ACTION_W   = 1;
    localparam int unsigned CHANNEL_W  = 4;
    localparam int unsigned MASK_W     = 13;
    localparam int unsigned BEEP_W     = 3;
    localparam int unsigned MISS_W     = 8;
    localparam int unsigned RATE_W     = 10;
    localparam int unsigned LIMIT_W    = 8;
    localparam int unsigned THR_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [MISS_W-1:0] MISS_MAX = '1;

    // Input action codes.
    localparam logic [ACTION_W-1:0] ACT_FRAME  = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_WINDOW = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_BASE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_REMOTE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_REFEREE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_HOST     = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [RATE_W-1:0]  RST_RATE_SCALE  = 10'd5;
    localparam logic [LIMIT_W-1:0] RST_MISS_LIMIT  = 8'd2;
    localparam logic [THR_W-1:0]   RST_THR_BASE    = 16'd200;
    localparam logic [THR_W-1:0]   RST_THR_HIGH    = 16'd850;
    localparam logic [THR_W-1:0]   RST_THR_REMOTE  = 16'd60;
    localparam logic [THR_W-1:0]   RST_THR_REFEREE = 16'd20;
    localparam logic [THR_W-1:0]   RST_THR_HOST    = 16'd40;

    // Buzzer priority levels.
    localparam logic [BEEP_W-1:0] BEEP_SILENT   = 3'd0;
    localparam logic [BEEP_W-1:0] BEEP_LINK     = 3'd1;
    localparam logic [BEEP_W-1:0] BEEP_MOTOR    = 3'd2;
    localparam logic [BEEP_W-1:0] BEEP_INERTIAL = 3'd3;
    localparam logic [BEEP_W-1:0] BEEP_REMOTE   = 3'd4;

    typedef enum logic [2:0] {
        THR_SEL_BASE,
        THR_SEL_HIGH,
        THR_SEL_REMOTE,
        THR_SEL_REFEREE,
        THR_SEL_HOST
    } thr_sel_t;

    typedef struct packed {
        logic [MISS_W-1:0] miss;
        logic              offline;
    } verdict_t;

    function automatic thr_sel_t thr_class_of(input int unsigned ch);
        thr_sel_t sel;
        case (ch) inside
            5, 7, [10:12]: sel = THR_SEL_HIGH;
            6:             sel = THR_SEL_REMOTE;
            8:             sel = THR_SEL_REFEREE;
            9:             sel = THR_SEL_HOST;
            default:       sel = THR_SEL_BASE;
        endcase
        return sel;
    endfunction

    function automatic logic [BEEP_W-1:0] beep_class_of(input int unsigned ch);
        logic [BEEP_W-1:0] lvl;
        case (ch) inside
            6:               lvl = BEEP_REMOTE;
            0, 5, 7:         lvl = BEEP_INERTIAL;
            [1:4], [10:12]:  lvl = BEEP_MOTOR;
            8, 9:            lvl = BEEP_LINK;
            default:         lvl = BEEP_SILENT;
        endcase
        return lvl;
    endfunction

endpackage

// File: rtl/llm_if.sv
// Valid/ready channel interfaces for the monitor's input items and results.
interface llm_in_if
    import llm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [CHANNEL_W-1:0] channel;

    modport source (output valid, action, channel, input ready);
    modport sink   (input valid, action, channel, output ready);
endinterface

interface llm_out_if
    import llm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] error_mask;
    logic              any_error;
    logic [BEEP_W-1:0] beep_level;

    modport source (output valid, error_mask, any_error, beep_level, input ready);
    modport sink   (input valid, error_mask, any_error, beep_level, output ready);
endinterface

// File: rtl/link_liveness_monitor.sv
// Top level of the per-channel link liveness monitor.
//
// Each input request is either a frame seen on a channel or a window end. Frame
// requests are taken one per cycle while no window end is in progress: they
// read the channel's entry from a single state memory, add one to its frame
// count (saturating) and write it back from the modify stage, with the last
// write forwarded so that back-to-back frames on the same channel count
// correctly. Frames for a channel index of NUM_CHANNELS or more are taken and
// dropped. A window end holds off input while a sequencer walks every entry
// through the same read port and judges it (rate = count * rate_scale, saturated,
// against the channel's threshold class), updates its miss counter, clears its
// frame count and folds its offline flag into the result. The result request
// then leaves through an output register; if the previous result has not been
// taken yet, the walk waits in its last step until the register frees, and no
// requests are taken meanwhile. After reset every entry reads as zero through
// per-entry valid bits, so there is no clearing pass. Configuration writes are
// expected only while no request is in flight.
module link_liveness_monitor
    import llm_pkg::*;
#(
    parameter int unsigned NUM_CHANNELS = 13,
    parameter int unsigned COUNT_WIDTH  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    llm_in_if.sink                items,
    llm_out_if.source             results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

    typedef struct packed {
        logic [MISS_W-1:0]      miss;
        logic [COUNT_WIDTH-1:0] count;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Configuration registers.
    logic [RATE_W-1:0]  rate_scale_reg;
    logic [LIMIT_W-1:0] miss_limit_reg;
    logic [THR_W-1:0]   thr_base_reg;
    logic [THR_W-1:0]   thr_high_reg;
    logic [THR_W-1:0]   thr_remote_reg;
    logic [THR_W-1:0]   thr_referee_reg;
    logic [THR_W-1:0]   thr_host_reg;

    // State memory with registered read data and per-entry valid bits.
    entry_t             mem [NUM_CHANNELS];
    entry_t             rd_data_reg;
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic [IDX_W-1:0]   rd_addr;

    // Sequencer, modify stage and forwarding register.
    state_t             state_reg;
    logic [IDX_W-1:0]   walk_idx_reg;
    logic               s1_valid_reg;
    logic               s1_eval_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               fwd_valid_reg;
    logic [IDX_W-1:0]   fwd_addr_reg;
    entry_t             fwd_data_reg;

    // Window accumulators and output register.
    logic [MASK_W-1:0]  mask_reg;
    logic [MASK_W-1:0]  mask_next;
    logic               any_reg;
    logic               any_next;
    logic [BEEP_W-1:0]  level_reg;
    logic [BEEP_W-1:0]  level_next;
    logic               out_valid_reg;
    logic [MASK_W-1:0]  out_mask_reg;
    logic               out_any_reg;
    logic [BEEP_W-1:0]  out_level_reg;
    logic               out_load;

    logic               in_range;
    logic [IDX_W-1:0]   chan_idx;
    logic               frame_take;
    logic               window_take;
    entry_t             cur_entry;
    entry_t             wr_data;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [THR_W-1:0]   thr;
    logic [BEEP_W-1:0]  chan_level;
    verdict_t           verdict;

    assign items.ready = (state_reg == ST_IDLE);

    assign in_range    = 32'(items.channel) < NUM_CHANNELS;
    assign chan_idx    = in_range ? IDX_W'(items.channel) : '0;
    assign frame_take  = items.valid && items.ready && (items.action == ACT_FRAME) && in_range;
    assign window_take = items.valid && items.ready && (items.action == ACT_WINDOW);

    assign rd_addr = (state_reg == ST_WALK) ? walk_idx_reg : chan_idx;

    // The finished window result moves into the output register once it is free
    // or being emptied at this edge.
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || results.ready);

    assign results.valid      = out_valid_reg;
    assign results.error_mask = out_mask_reg;
    assign results.any_error  = out_any_reg;
    assign results.beep_level = out_level_reg;

    // Configuration writes; indexes past the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_scale_reg  <= RST_RATE_SCALE;
            miss_limit_reg  <= RST_MISS_LIMIT;
            thr_base_reg    <= RST_THR_BASE;
            thr_high_reg    <= RST_THR_HIGH;
            thr_remote_reg  <= RST_THR_REMOTE;
            thr_referee_reg <= RST_THR_REFEREE;
            thr_host_reg    <= RST_THR_HOST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RATE_SCALE:  rate_scale_reg  <= cfg_wdata[RATE_W-1:0];
                CFG_MISS_LIMIT:  miss_limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                CFG_THR_BASE:    thr_base_reg    <= cfg_wdata[THR_W-1:0];
                CFG_THR_HIGH:    thr_high_reg    <= cfg_wdata[THR_W-1:0];
                CFG_THR_REMOTE:  thr_remote_reg  <= cfg_wdata[THR_W-1:0];
                CFG_THR_REFEREE: thr_referee_reg <= cfg_wdata[THR_W-1:0];
                CFG_THR_HOST:    thr_host_reg    <= cfg_wdata[THR_W-1:0];
                default:         ;
            endcase
        end
    end

    // The memory itself: one write and one registered read per cycle. A read of
    // the entry written at the same edge returns the old contents.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            mem[s1_idx_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            valid_reg[s1_idx_reg] <= 1'b1;
        end
    end

    // Current contents of the entry in the modify stage. The write committed at
    // the edge that issued this read is not in the read data, so it is forwarded.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_idx_reg))
        begin
            cur_entry = fwd_data_reg;
        end
        else if (valid_reg[s1_idx_reg])
        begin
            cur_entry = rd_data_reg;
        end
        else
        begin
            cur_entry = '0;
        end
    end

    always_comb
    begin
        case (thr_class_of(32'(s1_idx_reg)))
            THR_SEL_HIGH:    thr = thr_high_reg;
            THR_SEL_REMOTE:  thr = thr_remote_reg;
            THR_SEL_REFEREE: thr = thr_referee_reg;
            THR_SEL_HOST:    thr = thr_host_reg;
            default:         thr = thr_base_reg;
        endcase
    end

    llm_judge #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_judge (
        .count      (cur_entry.count),
        .miss       (cur_entry.miss),
        .rate_scale (rate_scale_reg),
        .threshold  (thr),
        .miss_limit (miss_limit_reg),
        .verdict    (verdict)
    );

    // Frame count saturates at its all-ones value.
    assign count_inc = (&cur_entry.count) ? cur_entry.count
                                          : cur_entry.count + COUNT_WIDTH'(1);

    always_comb
    begin
        if (s1_eval_reg)
        begin
            wr_data.miss  = verdict.miss;
            wr_data.count = '0;
        end
        else
        begin
            wr_data.miss  = cur_entry.miss;
            wr_data.count = count_inc;
        end
    end

    // Fold the verdict of the channel being judged into the window result.
    // Channels past the mask width still raise the alarm flag.
    assign chan_level = beep_class_of(32'(s1_idx_reg));

    always_comb
    begin
        mask_next  = mask_reg;
        any_next   = any_reg;
        level_next = level_reg;
        if (verdict.offline)
        begin
            any_next = 1'b1;
            if (32'(s1_idx_reg) < MASK_W)
            begin
                mask_next = mask_reg | (MASK_W'(1) << s1_idx_reg);
            end
            if (chan_level > level_reg)
            begin
                level_next = chan_level;
            end
        end
    end

    // Sequencer, modify stage, accumulators and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            walk_idx_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s1_eval_reg   <= 1'b0;
            s1_idx_reg    <= '0;
            fwd_valid_reg <= 1'b0;
            fwd_addr_reg  <= '0;
            fwd_data_reg  <= '0;
            mask_reg      <= '0;
            any_reg       <= 1'b0;
            level_reg     <= BEEP_SILENT;
            out_valid_reg <= 1'b0;
            out_mask_reg  <= '0;
            out_any_reg   <= 1'b0;
            out_level_reg <= BEEP_SILENT;
        end
        else
        begin
            fwd_valid_reg <= s1_valid_reg;
            fwd_addr_reg  <= s1_idx_reg;
            fwd_data_reg  <= wr_data;

            s1_valid_reg  <= frame_take || (state_reg == ST_WALK);
            s1_eval_reg   <= (state_reg == ST_WALK);
            s1_idx_reg    <= rd_addr;

            if (window_take)
            begin
                mask_reg  <= '0;
                any_reg   <= 1'b0;
                level_reg <= BEEP_SILENT;
            end
            else if (s1_valid_reg && s1_eval_reg)
            begin
                mask_reg  <= mask_next;
                any_reg   <= any_next;
                level_reg <= level_next;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_mask_reg  <= mask_reg;
                out_any_reg   <= any_reg;
                out_level_reg <= level_reg;
            end
            else if (results.valid && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (window_take)
                    begin
                        walk_idx_reg <= '0;
                        state_reg    <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (walk_idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        walk_idx_reg <= walk_idx_reg + IDX_W'(1);
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Every walk cycle feeds a judgement into the modify stage.
    a_walk_feeds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |=> (s1_valid_reg && s1_eval_reg))
        else $error("walk step did not reach the modify stage");

    // A result only appears at the end of a walk.
    a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the end of a walk");

    // Any flagged channel or buzzer level implies the alarm flag.
    a_alarm_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_mask_reg != '0) || (out_level_reg != BEEP_SILENT)))
        |-> out_any_reg)
        else $error("offline channel reported without alarm flag");

    // A window end holds off the next request.
    a_window_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        window_take |=> !items.ready)
        else $error("request taken during a window walk");

endmodule

// File: rtl/llm_judge.sv
// Window judgement of one channel: scaled rate, threshold compare and miss counter update.
module llm_judge
    import llm_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic [COUNT_WIDTH-1:0] count,
    input  logic [MISS_W-1:0]      miss,
    input  logic [RATE_W-1:0]      rate_scale,
    input  logic [THR_W-1:0]       threshold,
    input  logic [LIMIT_W-1:0]     miss_limit,
    output verdict_t               verdict
);

    localparam int unsigned PROD_W = COUNT_WIDTH + RATE_W;
    localparam int unsigned CMP_W  = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
    localparam logic [PROD_W-1:0] SAT_LIMIT = PROD_W'({COUNT_WIDTH{1'b1}});

    logic [PROD_W-1:0]      product;
    logic [COUNT_WIDTH-1:0] rate;
    logic                   low_rate;
    logic [MISS_W-1:0]      miss_upd;

    assign product = PROD_W'(count) * PROD_W'(rate_scale);

    always_comb
    begin
        if (product > SAT_LIMIT)
        begin
            rate = '1;
        end
        else
        begin
            rate = product[COUNT_WIDTH-1:0];
        end
        low_rate = CMP_W'(rate) < CMP_W'(threshold);
        if (!low_rate)
        begin
            miss_upd = '0;
        end
        else if (miss == MISS_MAX)
        begin
            miss_upd = miss;
        end
        else
        begin
            miss_upd = miss + MISS_W'(1);
        end
        verdict.miss    = miss_upd;
        verdict.offline = miss_upd > miss_limit;
    end

endmodule
